// ===== rtl/quick_sort_hoare_middle_pivot_core_defines.svh =====
// Assertion macros used by the sorter engine.
`ifndef QUICK_SORT_HOARE_MIDDLE_PIVOT_CORE_DEFINES_SVH
`define QUICK_SORT_HOARE_MIDDLE_PIVOT_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define QS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define QS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qsort_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package qsort_pkg;
  localparam int unsigned Depth = 64;
  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned DataW = 32;
  localparam int unsigned QDepth = 2;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  // Command handed from the front end to the sort engine.
  typedef struct packed {
    logic               store;
    logic               last;
    logic signed [DataW-1:0] value;
  } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/qsort_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface qsort_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      value;
  logic                    last;
  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/qsort_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Classifies input beats and queues them for the engine.
module qsort_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  qsort_if.sink                in_i,
  output qsort_pkg::cmd_t      cmd_o,
  output logic                 cmd_valid_o,
  input  wire                  cmd_ready_i
);
  qsort_pkg::cmd_t fifo_q [qsort_pkg::QDepth];
  logic [0:0] wp_q, rp_q;
  logic [1:0] cnt_q;
  qsort_pkg::cnt_t fill_q, fill_d;
  logic push, pop;

  assign in_i.ready = (cnt_q != 2'(qsort_pkg::QDepth));
  assign push = in_i.valid && in_i.ready;
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = fifo_q[rp_q];

  // Front keeps its own count so that overflow items are marked as dropped.
  always_comb begin
    fill_d = fill_q;
    if (push) begin
      if (in_i.last) begin
        fill_d = '0;
      end else if (fill_q != qsort_pkg::cnt_t'(qsort_pkg::Depth)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q].store <= (fill_q != qsort_pkg::cnt_t'(qsort_pkg::Depth));
      fifo_q[wp_q].last <= in_i.last;
      fifo_q[wp_q].value <= in_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/qsort_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "quick_sort_hoare_middle_pivot_core_defines.svh"
// Stores elements, sorts them in place with an explicit range stack, then
// streams them out. The element store and the range stack each have one
// write port and one registered read port.
module qsort_engine (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  qsort_pkg::cmd_t      cmd_i,
  input  wire                  cmd_valid_i,
  output logic                 cmd_ready_o,
  qsort_if.source              out_o
);
  typedef enum logic [4:0] {
    S_LOAD, S_POP, S_POPW, S_PIV, S_PIVL, S_CHK, S_RDI, S_CMPI, S_RDJ, S_CMPJ,
    S_SWP, S_WRJ, S_END, S_END_R, S_ORD, S_OSET, S_OWAIT
  } state_e;

  // Partition indices run from one below the range to one above it.
  typedef logic signed [qsort_pkg::IdxW+1:0] sidx_t;

  logic signed [qsort_pkg::DataW-1:0] mem_q [qsort_pkg::Depth];
  logic [2*qsort_pkg::IdxW-1:0]       stk_q [qsort_pkg::Depth];

  state_e                       state_q;
  qsort_pkg::cnt_t              cnt_q, sp_q, k_q;
  sidx_t                        lo_q, hi_q, i_q, j_q;
  logic signed [qsort_pkg::DataW-1:0] piv_q, rd_q, vi_q, vj_q, out_d_q;
  logic                         out_v_q, out_l_q;
  logic [2*qsort_pkg::IdxW-1:0] stk_rd_q;

  qsort_pkg::idx_t              raddr, mem_waddr, stk_waddr;
  logic                         mem_we, stk_we;
  logic signed [qsort_pkg::DataW-1:0] mem_wdata;
  logic [2*qsort_pkg::IdxW-1:0] stk_wdata;
  logic [qsort_pkg::IdxW:0]     mid_sum;
  qsort_pkg::cnt_t              n_cmd, last_idx, sp_dec, cnt_dec;
  sidx_t                        i_inc, j_dec;

  assign cmd_ready_o = (state_q == S_LOAD);
  assign out_o.valid = out_v_q;
  assign out_o.value = out_d_q;
  assign out_o.last = out_l_q;

  assign n_cmd = cnt_q + qsort_pkg::cnt_t'(cmd_i.store);
  assign last_idx = n_cmd - qsort_pkg::cnt_t'(1);
  assign sp_dec = sp_q - qsort_pkg::cnt_t'(1);
  assign cnt_dec = cnt_q - qsort_pkg::cnt_t'(1);
  assign mid_sum = {1'b0, lo_q[qsort_pkg::IdxW-1:0]} + {1'b0, hi_q[qsort_pkg::IdxW-1:0]};
  assign i_inc = i_q + sidx_t'(1);
  assign j_dec = j_q - sidx_t'(1);

  always_comb begin
    unique case (state_q)
      S_PIV:   raddr = mid_sum[qsort_pkg::IdxW:1];
      S_RDJ:   raddr = j_q[qsort_pkg::IdxW-1:0];
      S_ORD:   raddr = k_q[qsort_pkg::IdxW-1:0];
      default: raddr = i_q[qsort_pkg::IdxW-1:0];
    endcase
  end

  // Element store writes: loading, then the two halves of a swap.
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = cnt_q[qsort_pkg::IdxW-1:0];
    mem_wdata = cmd_i.value;
    unique case (state_q)
      S_LOAD: mem_we = cmd_valid_i && cmd_i.store;
      S_SWP: begin
        mem_we = (i_q <= j_q);
        mem_waddr = i_q[qsort_pkg::IdxW-1:0];
        mem_wdata = vj_q;
      end
      S_WRJ: begin
        mem_we = 1'b1;
        mem_waddr = j_q[qsort_pkg::IdxW-1:0];
        mem_wdata = vi_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Range stack writes: the whole set at the close, then the left and right
  // subranges of each partition on consecutive cycles.
  always_comb begin
    stk_we = 1'b0;
    stk_waddr = sp_q[qsort_pkg::IdxW-1:0];
    stk_wdata = {lo_q[qsort_pkg::IdxW-1:0], j_q[qsort_pkg::IdxW-1:0]};
    unique case (state_q)
      S_LOAD: begin
        stk_we = cmd_valid_i && cmd_i.last && (n_cmd >= qsort_pkg::cnt_t'(2));
        stk_waddr = '0;
        stk_wdata = {{qsort_pkg::IdxW{1'b0}}, last_idx[qsort_pkg::IdxW-1:0]};
      end
      S_END: stk_we = (j_q > lo_q);
      S_END_R: begin
        stk_we = (hi_q > i_q);
        stk_wdata = {i_q[qsort_pkg::IdxW-1:0], hi_q[qsort_pkg::IdxW-1:0]};
      end
      default: stk_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_q[stk_waddr] <= stk_wdata;
    stk_rd_q <= stk_q[sp_dec[qsort_pkg::IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q <= '0;
      sp_q <= '0;
      k_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      i_q <= '0;
      j_q <= '0;
      piv_q <= '0;
      vi_q <= '0;
      vj_q <= '0;
      out_v_q <= 1'b0;
      out_l_q <= 1'b0;
      out_d_q <= '0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (cmd_valid_i) begin
            cnt_q <= n_cmd;
            if (cmd_i.last) begin
              k_q <= '0;
              if (n_cmd >= qsort_pkg::cnt_t'(2)) begin
                sp_q <= qsort_pkg::cnt_t'(1);
                state_q <= S_POP;
              end else begin
                state_q <= S_ORD;
              end
            end
          end
        end
        S_POP: begin
          if (sp_q == '0) begin
            state_q <= S_ORD;
          end else begin
            sp_q <= sp_dec;
            state_q <= S_POPW;
          end
        end
        S_POPW: begin
          lo_q <= sidx_t'(stk_rd_q[2*qsort_pkg::IdxW-1:qsort_pkg::IdxW]);
          hi_q <= sidx_t'(stk_rd_q[qsort_pkg::IdxW-1:0]);
          i_q <= sidx_t'(stk_rd_q[2*qsort_pkg::IdxW-1:qsort_pkg::IdxW]);
          j_q <= sidx_t'(stk_rd_q[qsort_pkg::IdxW-1:0]);
          state_q <= S_PIV;
        end
        S_PIV: state_q <= S_PIVL;
        S_PIVL: begin
          piv_q <= rd_q;
          state_q <= S_CHK;
        end
        S_CHK: state_q <= (j_q >= i_q) ? S_RDI : S_END;
        S_RDI: state_q <= (i_q <= hi_q) ? S_CMPI : S_RDJ;
        S_CMPI: begin
          if (rd_q < piv_q) begin
            i_q <= i_inc;
            state_q <= S_RDI;
          end else begin
            vi_q <= rd_q;
            state_q <= S_RDJ;
          end
        end
        S_RDJ: state_q <= (j_q >= lo_q) ? S_CMPJ : S_SWP;
        S_CMPJ: begin
          if (rd_q > piv_q) begin
            j_q <= j_dec;
            state_q <= S_RDJ;
          end else begin
            vj_q <= rd_q;
            state_q <= S_SWP;
          end
        end
        S_SWP: state_q <= (i_q <= j_q) ? S_WRJ : S_END;
        S_WRJ: begin
          i_q <= i_inc;
          j_q <= j_dec;
          state_q <= S_CHK;
        end
        S_END: begin
          if (j_q > lo_q) sp_q <= sp_q + qsort_pkg::cnt_t'(1);
          state_q <= S_END_R;
        end
        S_END_R: begin
          if (hi_q > i_q) sp_q <= sp_q + qsort_pkg::cnt_t'(1);
          state_q <= S_POP;
        end
        S_ORD: state_q <= S_OSET;
        S_OSET: begin
          out_d_q <= rd_q;
          out_l_q <= (k_q == cnt_dec);
          out_v_q <= 1'b1;
          state_q <= S_OWAIT;
        end
        S_OWAIT: begin
          if (out_o.ready) begin
            out_v_q <= 1'b0;
            if (out_l_q) begin
              cnt_q <= '0;
              k_q <= '0;
              state_q <= S_LOAD;
            end else begin
              k_q <= k_q + qsort_pkg::cnt_t'(1);
              state_q <= S_ORD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  `QS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready, out_o.valid && $stable(out_o.value) && $stable(out_o.last), "output beat changed before it was taken")
  `QS_ASSERT(a_no_out_in_load, clk_i, rst_ni, !(out_o.valid && cmd_ready_o), "output beat offered while loading")
  `QS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= qsort_pkg::cnt_t'(qsort_pkg::Depth), "element count above the store depth")
  `QS_ASSERT(a_sp_bound, clk_i, rst_ni, sp_q <= qsort_pkg::cnt_t'(qsort_pkg::Depth / 2), "range stack deeper than half the store")
endmodule
`default_nettype wire

// ===== rtl/quick_sort_hoare_middle_pivot_core.sv =====
// Sorter for sets of up to 64 signed 32-bit values. Each input beat carries
// one value; the beat with last set closes the set. Values beyond the 64th
// are dropped, but a closing beat always starts the sort of what was stored.
// The set is sorted in place by quicksort with a Hoare partition around the
// middle element, using an explicit stack of index ranges, and is then sent
// out in ascending order with last set on the final beat. Timing: while the
// block loads, it takes one beat per cycle. A two-entry queue sits between
// the input and the engine, so once the engine is sorting or draining, the
// input stalls after at most two more beats. Popping a range and fetching
// its pivot steps through pop, stack read, pivot address and pivot latch;
// an element compare gives the address, then compares on the registered
// read; an outer loop check, each swap write and each subrange push has its
// own state. The total follows the number of compares, about n log n on
// average and n squared at worst. Each value is read, registered and held
// until taken; the next set is taken only after the final beat is accepted.
`timescale 1ns / 1ps
`default_nettype none
module quick_sort_hoare_middle_pivot_core (
  input wire clk_i,
  input wire rst_ni,
  qsort_if.sink in_i,
  qsort_if.source out_o
);
  // Classified beats travel from the front end to the engine.
  qsort_pkg::cmd_t cmd;
  logic            cmd_valid;
  logic            cmd_ready;

  // The front end marks beats beyond the store depth so the engine skips them.
  qsort_front i_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready)
  );

  // The engine loads, sorts and drains one set at a time.
  qsort_engine i_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .out_o      (out_o)
  );
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qsort_if in_if();
  qsort_if out_if();

  quick_sort_hoare_middle_pivot_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } beat_t;

  // Predictor state: the set being collected and the sorted values still owed.
  logic signed [31:0] set_store[qsort_pkg::Depth];
  int unsigned        set_count;
  beat_t              sorted_q[$];
  int                 error_count;
  int                 beats_sent;
  int                 beats_checked;
  int                 sets_closed;
  logic               hold_off;

  // Directed rows. Where a row's expected value is obvious it is given, and
  // the predicted value is checked against it too.
  typedef struct {
    logic signed [31:0] value;
    logic               last;
    logic               has_exp;
    logic signed [31:0] exp_value;
  } row_t;

  row_t directed_rows[$];

  // Hoare partition quicksort with a middle pivot, driven by an explicit
  // stack of index ranges as the hardware does it.
  task automatic sort_collected_set();
    int lo_stack[$];
    int hi_stack[$];
    int lo;
    int hi;
    int i;
    int j;
    logic signed [31:0] pivot;
    logic signed [31:0] swap_tmp;
    if (set_count >= 2) begin
      lo_stack.push_back(0);
      hi_stack.push_back(set_count - 1);
    end
    while (lo_stack.size() > 0) begin
      lo = lo_stack.pop_back();
      hi = hi_stack.pop_back();
      pivot = set_store[(lo + hi) / 2];
      i = lo;
      j = hi;
      while (j >= i) begin
        while (i <= hi && set_store[i] < pivot) i++;
        while (j >= lo && set_store[j] > pivot) j--;
        if (i <= j) begin
          swap_tmp = set_store[i];
          set_store[i] = set_store[j];
          set_store[j] = swap_tmp;
          j--;
          i++;
        end
      end
      if (j > lo) begin
        lo_stack.push_back(lo);
        hi_stack.push_back(j);
      end
      if (hi > i) begin
        lo_stack.push_back(i);
        hi_stack.push_back(hi);
      end
    end
    for (int k = 0; k < set_count; k++) begin
      sorted_q.push_back('{value: set_store[k], last: (k == set_count - 1)});
    end
    set_count = 0;
    sets_closed++;
  endtask

  task automatic predict_beat(input logic signed [31:0] value, input logic last);
    if (set_count < qsort_pkg::Depth) begin
      set_store[set_count] = value;
      set_count++;
    end
    if (last) sort_collected_set();
  endtask

  // Drive one beat and wait until the block takes it.
  task automatic send_beat(input logic signed [31:0] value, input logic last);
    in_if.valid <= 1'b1;
    in_if.value <= value;
    in_if.last  <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_beat(value, last);
    beats_sent++;
  endtask

  // Gap between bursts; apart from the end of the test, valid is dropped only here.
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] random_value(input int mode);
    case (mode)
      0: return $urandom_range(0, 7) - 4;
      1: return {1'b1, 31'($urandom)};
      2: return {1'b0, 31'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Sends a full set of n elements, the last one flagged.
  task automatic send_set(input int n, input int mode, input int burst_max);
    int burst;
    burst = $urandom_range(1, burst_max);
    for (int k = 0; k < n; k++) begin
      send_beat(random_value(mode), k == n - 1);
      burst--;
      if (burst == 0) begin
        idle_gap($urandom_range(0, 4));
        burst = $urandom_range(1, burst_max);
      end
    end
  endtask

  // Receiver: random stalls while bit 5 of the sent-beat count is clear, with one
  // long hold-off while the sender keeps pushing, so the block backs up into its input.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) out_if.ready <= 1'b0;
      else if (beats_sent[5]) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    int stall_cycles;
    hold_off = 1'b0;
    @(posedge rst_ni);
    wait (beats_sent >= 140);
    hold_off = 1'b1;
    for (stall_cycles = 0; stall_cycles < 3000; stall_cycles++) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Result checker: every accepted beat against the oldest prediction.
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (sorted_q.size() == 0) begin
        $error("value_res: unexpected beat, actual %0d", out_if.value);
        error_count++;
      end else begin
        want = sorted_q.pop_front();
        if (out_if.value !== want.value) begin
          $error("value_res: expected %0d, actual %0d", want.value, out_if.value);
          error_count++;
        end
        if (out_if.last !== want.last) begin
          $error("last_res: expected %0b, actual %0b", want.last, out_if.last);
          error_count++;
        end
        beats_checked++;
      end
    end
  end

  initial begin
    #20ms;
    $display("quick_sort_hoare_middle_pivot_core regression: fail");
    $finish;
  end

  initial begin
    int gap;
    int set_first;
    int set_len;
    int base;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    in_if.last  <= 1'b0;
    set_count = 0;
    error_count = 0;
    beats_sent = 0;
    beats_checked = 0;
    sets_closed = 0;

    // Directed sets: single elements at the extremes, a pair, a set of four with a
    // repeated value, descending order, and a run of duplicates.
    directed_rows.push_back('{32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff});
    directed_rows.push_back('{32'sh80000000, 1'b1, 1'b1, 32'sh80000000});
    directed_rows.push_back('{32'sh7fffffff, 1'b0, 1'b1, 32'sh80000000});
    directed_rows.push_back('{32'sh80000000, 1'b1, 1'b1, 32'sh7fffffff});
    directed_rows.push_back('{32'sd5, 1'b0, 1'b1, -32'sd1});
    directed_rows.push_back('{32'sd5, 1'b0, 1'b1, 32'sd0});
    directed_rows.push_back('{-32'sd1, 1'b0, 1'b1, 32'sd5});
    directed_rows.push_back('{32'sd0, 1'b1, 1'b1, 32'sd5});
    for (int k = 0; k < 8; k++)
      directed_rows.push_back('{32'(8 - k), k == 7, 1'b0, '0});
    for (int k = 0; k < 6; k++)
      directed_rows.push_back('{32'sd3, k == 5, 1'b0, '0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Each closed set's predictions sit at the tail of the queue; older sets
    // may still be waiting ahead of them.
    set_first = 0;
    foreach (directed_rows[r]) begin
      send_beat(directed_rows[r].value, directed_rows[r].last);
      if (directed_rows[r].last) begin
        if (directed_rows[r].has_exp) begin
          set_len = r - set_first + 1;
          base = sorted_q.size() - set_len;
          for (int q = 0; q < set_len; q++) begin
            if (sorted_q[base + q].value !== directed_rows[set_first + q].exp_value) begin
              $error("value_res: expected %0d, actual %0d",
                     directed_rows[set_first + q].exp_value, sorted_q[base + q].value);
              error_count++;
            end
          end
        end
        set_first = r + 1;
      end
    end

    // Store overflow: 66 elements, the last two are dropped.
    for (int k = 0; k < 66; k++) send_beat(random_value(3), k == 65);

    // Random sets, mostly small, with a full-depth one now and then.
    while (beats_sent < 300) begin
      if ($urandom_range(0, 9) == 0) send_set(qsort_pkg::Depth, $urandom_range(0, 3), 16);
      else send_set($urandom_range(1, 12), $urandom_range(0, 3), 6);
      gap = $urandom_range(0, 3);
      idle_gap(gap == 0 ? 0 : $urandom_range(0, 10));
    end
    in_if.valid <= 1'b0;

    wait (sorted_q.size() == 0);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d elements in %0d sets, checked %0d sorted beats.",
             beats_sent, sets_closed, beats_checked);
    if (error_count == 0) begin
      $display("quick_sort_hoare_middle_pivot_core regression: pass");
    end else begin
      $display("quick_sort_hoare_middle_pivot_core regression: fail");
    end
    $finish;
  end
endmodule
